/* hw/rtl/dpbp_pkg.sv */
// types, constants and step functions for the depth pixel back-projection pipeline
// used by depth_pixel_back_projection; depends on nothing else
package dpbp_pkg;

    localparam int DataW       = 16;
    localparam int IdxW        = 12;
    localparam int ColorW      = 8;
    localparam int CoordW      = 24;
    localparam int MagW        = 2 * DataW;
    localparam int BitsPerStep = 2;
    localparam int DivStages   = CoordW / BitsPerStep;
    localparam int NumStages   = DivStages + 4;
    localparam int InDataW     = 64;
    localparam int OutDataW    = 88;
    localparam int CfgIdxW     = 3;

    localparam logic [DataW:0] MaxWidth  = 17'd4096;
    localparam logic [DataW:0] MaxHeight = 17'd4096;

    localparam logic [CoordW-1:0] PosSat = 24'h7FFFFF;
    localparam logic [CoordW-1:0] NegSat = 24'h800000;

    localparam logic [DataW-1:0] ResetCenterX = 16'd5120;
    localparam logic [DataW-1:0] ResetCenterY = 16'd3840;
    localparam logic [DataW-1:0] ResetFocalX  = 16'd9600;
    localparam logic [DataW-1:0] ResetFocalY  = 16'd9600;
    localparam logic [DataW-1:0] ResetNear    = 16'd819;
    localparam logic [DataW-1:0] ResetFar     = 16'd16384;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_FOCAL_X  = 3'd2,
        CFG_FOCAL_Y  = 3'd3,
        CFG_NEAR     = 3'd4,
        CFG_FAR      = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [ColorW-1:0] blue;
        logic [ColorW-1:0] green;
        logic [ColorW-1:0] red;
    } color_t;

    typedef struct packed {
        logic             ok;
        logic             neg_x;
        logic             neg_y;
        logic [DataW-1:0] dx;
        logic [DataW-1:0] dy;
        logic [DataW-1:0] depth;
        color_t           color;
    } prep_t;

    typedef struct packed {
        logic            ok;
        logic            neg_x;
        logic            neg_y;
        logic [MagW-1:0] mag_x;
        logic [MagW-1:0] mag_y;
        logic [DataW-1:0] depth;
        color_t          color;
    } mult_t;

    typedef struct packed {
        logic [DataW-1:0]  rem;
        logic [CoordW-1:0] work;
    } axis_t;

    typedef struct packed {
        logic             ok;
        logic             neg_x;
        logic             neg_y;
        logic             sat_x;
        logic             sat_y;
        logic             zero_x;
        logic             zero_y;
        axis_t            ax;
        axis_t            ay;
        logic [DataW-1:0] depth;
        color_t           color;
    } div_t;

    typedef struct packed {
        logic              ok;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [DataW-1:0]  z;
        color_t            color;
    } result_t;

    // one restoring division step: shift in the next dividend bit, emit one quotient bit
    function automatic axis_t div_bit(axis_t a, logic [DataW-1:0] focal);
        logic [DataW:0] trial;
        logic           q;
        axis_t          r;
        trial = {a.rem, a.work[CoordW-1]};
        q     = (trial >= {1'b0, focal});
        if (q)
        begin
            trial = trial - {1'b0, focal};
        end
        r.rem  = trial[DataW-1:0];
        r.work = {a.work[CoordW-2:0], q};
        return r;
    endfunction

    function automatic logic [CoordW-1:0] finish_axis(logic [CoordW-1:0] q, logic neg,
                                                     logic sat, logic zero);
        logic [CoordW-1:0] r;
        if (zero)
        begin
            r = '0;
        end
        else if (neg)
        begin
            if (sat || (q[CoordW-1] && (|q[CoordW-2:0])))
            begin
                r = NegSat;
            end
            else
            begin
                r = ~q + 1'b1;
            end
        end
        else if (sat || q[CoordW-1])
        begin
            r = PosSat;
        end
        else
        begin
            r = q;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/depth_pixel_back_projection.sv */
// depth pixel back-projection: pinhole model, one pixel in, one camera-space point out
// depends on dpbp_pkg
//
//  channel  | direction | request moves
//  s_*      | in        | tdata: pixel_row, pixel_col, depth, blue, green, red
//  m_*      | out       | tdata: point_x, point_y, point_z, out_blue, out_green, out_red;
//           |           | tuser: point_valid
//  cfg_*    | in        | write of one 16-bit register, no read-back
//
// one pixel per cycle while the output does not stall; the pipeline runs from input
// request to output request through an offset stage, a 16x16 multiplier stage, a
// saturation check, 12 divider stages of two quotient bits each, and an output register
// each stage has its own valid bit and takes data when it is empty or moving on,
// so a stall on the output fills bubbles before input ready drops
// reset clears the valid bits and loads the register defaults
module depth_pixel_back_projection
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dpbp_pkg::InDataW-1:0]        s_tdata,   // row, col, depth, blue, green, red
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dpbp_pkg::OutDataW-1:0]       m_tdata,   // x, y, z, blue, green, red
    output logic                                m_tuser,   // point_valid
    input  logic                                cfg_we,
    input  logic [dpbp_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [dpbp_pkg::DataW-1:0]          cfg_data
);

    localparam int NS = dpbp_pkg::NumStages;
    localparam int DS = dpbp_pkg::DivStages;

    logic [dpbp_pkg::DataW-1:0] center_x_reg, center_y_reg, focal_x_reg, focal_y_reg;
    logic [dpbp_pkg::DataW-1:0] near_reg, far_reg;

    logic [NS-1:0]         v_reg;
    logic [NS-1:0]         stage_ready;

    dpbp_pkg::prep_t       prep_reg, prep_next;
    dpbp_pkg::mult_t       mult_reg, mult_next;
    dpbp_pkg::div_t        div_reg  [DS+1];
    dpbp_pkg::div_t        div_next [DS+1];
    dpbp_pkg::result_t     out_reg, out_next;

    logic [dpbp_pkg::IdxW-1:0]  in_row, in_col;
    logic [dpbp_pkg::DataW-1:0] in_depth, scaled_x, scaled_y;
    logic                       in_range;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= dpbp_pkg::ResetCenterX;
            center_y_reg <= dpbp_pkg::ResetCenterY;
            focal_x_reg  <= dpbp_pkg::ResetFocalX;
            focal_y_reg  <= dpbp_pkg::ResetFocalY;
            near_reg     <= dpbp_pkg::ResetNear;
            far_reg      <= dpbp_pkg::ResetFar;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dpbp_pkg::CFG_CENTER_X: center_x_reg <= cfg_data;
                dpbp_pkg::CFG_CENTER_Y: center_y_reg <= cfg_data;
                dpbp_pkg::CFG_FOCAL_X:  focal_x_reg  <= cfg_data;
                dpbp_pkg::CFG_FOCAL_Y:  focal_y_reg  <= cfg_data;
                dpbp_pkg::CFG_NEAR:     near_reg     <= cfg_data;
                dpbp_pkg::CFG_FAR:      far_reg      <= cfg_data;
                default:                ;
            endcase
        end
    end

    // ready chain, back to front
    always_comb
    begin
        stage_ready[NS-1] = !v_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            stage_ready[i] = !v_reg[i] || stage_ready[i+1];
        end
    end

    assign s_tready = stage_ready[0];

    // stage 0: offsets from the principal point and range checks
    assign in_row   = s_tdata[11:0];
    assign in_col   = s_tdata[23:12];
    assign in_depth = s_tdata[39:24];
    assign scaled_x = {in_col, 4'b0000};
    assign scaled_y = {in_row, 4'b0000};
    assign in_range = ({5'b0, in_row} < dpbp_pkg::MaxHeight)
                   && ({5'b0, in_col} < dpbp_pkg::MaxWidth);

    always_comb
    begin
        prep_next.ok          = in_range && (in_depth > near_reg) && (in_depth < far_reg);
        prep_next.neg_x       = center_x_reg > scaled_x;
        prep_next.neg_y       = center_y_reg > scaled_y;
        prep_next.dx          = prep_next.neg_x ? (center_x_reg - scaled_x)
                                                : (scaled_x - center_x_reg);
        prep_next.dy          = prep_next.neg_y ? (center_y_reg - scaled_y)
                                                : (scaled_y - center_y_reg);
        prep_next.depth       = in_depth;
        prep_next.color.blue  = s_tdata[47:40];
        prep_next.color.green = s_tdata[55:48];
        prep_next.color.red   = s_tdata[63:56];
    end

    // stage 1: magnitudes
    always_comb
    begin
        mult_next.ok    = prep_reg.ok;
        mult_next.neg_x = prep_reg.neg_x;
        mult_next.neg_y = prep_reg.neg_y;
        mult_next.mag_x = {{dpbp_pkg::DataW{1'b0}}, prep_reg.dx}
                        * {{dpbp_pkg::DataW{1'b0}}, prep_reg.depth};
        mult_next.mag_y = {{dpbp_pkg::DataW{1'b0}}, prep_reg.dy}
                        * {{dpbp_pkg::DataW{1'b0}}, prep_reg.depth};
        mult_next.depth = prep_reg.depth;
        mult_next.color = prep_reg.color;
    end

    // stage 2: saturation check and divider seed, then two quotient bits per stage
    always_comb
    begin
        div_next[0].ok      = mult_reg.ok;
        div_next[0].neg_x   = mult_reg.neg_x;
        div_next[0].neg_y   = mult_reg.neg_y;
        div_next[0].sat_x   = {8'b0, mult_reg.mag_x[31:24]} >= focal_x_reg;
        div_next[0].sat_y   = {8'b0, mult_reg.mag_y[31:24]} >= focal_y_reg;
        div_next[0].zero_x  = (mult_reg.mag_x == '0);
        div_next[0].zero_y  = (mult_reg.mag_y == '0);
        div_next[0].ax.rem  = {8'b0, mult_reg.mag_x[31:24]};
        div_next[0].ax.work = mult_reg.mag_x[23:0];
        div_next[0].ay.rem  = {8'b0, mult_reg.mag_y[31:24]};
        div_next[0].ay.work = mult_reg.mag_y[23:0];
        div_next[0].depth   = mult_reg.depth;
        div_next[0].color   = mult_reg.color;
        for (int k = 1; k <= DS; k++)
        begin
            div_next[k] = div_reg[k-1];
            for (int b = 0; b < dpbp_pkg::BitsPerStep; b++)
            begin
                div_next[k].ax = dpbp_pkg::div_bit(div_next[k].ax, focal_x_reg);
                div_next[k].ay = dpbp_pkg::div_bit(div_next[k].ay, focal_y_reg);
            end
        end
    end

    // output stage: sign, saturation, zeroing of rejected pixels
    always_comb
    begin
        out_next = '0;
        if (div_reg[DS].ok)
        begin
            out_next.ok    = 1'b1;
            out_next.x     = dpbp_pkg::finish_axis(div_reg[DS].ax.work, div_reg[DS].neg_x,
                                                   div_reg[DS].sat_x, div_reg[DS].zero_x);
            out_next.y     = dpbp_pkg::finish_axis(div_reg[DS].ay.work, div_reg[DS].neg_y,
                                                   div_reg[DS].sat_y, div_reg[DS].zero_y);
            out_next.z     = div_reg[DS].depth;
            out_next.color = div_reg[DS].color;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (stage_ready[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (stage_ready[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (stage_ready[0] && s_tvalid)
        begin
            prep_reg <= prep_next;
        end
        if (stage_ready[1] && v_reg[0])
        begin
            mult_reg <= mult_next;
        end
        for (int k = 0; k <= DS; k++)
        begin
            if (stage_ready[k+2] && v_reg[k+1])
            begin
                div_reg[k] <= div_next[k];
            end
        end
        if (stage_ready[NS-1] && v_reg[NS-2])
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = v_reg[NS-1];
    assign m_tuser  = out_reg.ok;
    assign m_tdata  = {out_reg.color.red, out_reg.color.green, out_reg.color.blue,
                       out_reg.z, out_reg.y, out_reg.x};

    // rejected pixels leave as all zeros
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("rejected pixel carries nonzero data");

    // an accepted point has a depth above the near limit, so never zero
    a_point_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[63:48] != '0))
        else $error("accepted point with zero depth");

    // an input request always lands in the first stage
    a_input_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v_reg[0])
        else $error("input request lost at first stage");

endmodule
